// ===== hw/rtl/tgls_pkg.sv =====
package tgls_pkg;

   localparam int MAX_GROUP = 32;
   localparam int MAX_ITEMS = 65536;

   localparam int SCORE_W = 32;
   localparam int INDEX_W = 16;
   localparam int COUNT_W = 17;
   localparam int RANK_W  = 16;

   // member slot address within one bank, and member fill count
   localparam int GRP_AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int FILL_W = $clog2(MAX_GROUP + 1);

   // two banks of member slots, one filling while the other drains
   localparam int RAM_AW    = GRP_AW + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;

   localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] ITEM_COUNT_RST = COUNT_W'(MAX_ITEMS);
   localparam logic [FILL_W-1:0]  FILL_LIMIT     = FILL_W'(MAX_GROUP);

   // one closed group waiting to be reported
   typedef struct packed {
      logic               bank;
      logic [FILL_W-1:0]  fill;
      logic [COUNT_W-1:0] pos;
      logic [COUNT_W-1:0] neg;
      logic [RANK_W-1:0]  left;
      logic [RANK_W-1:0]  right;
      logic               ovf;
      logic               ends_step;
   } desc_type;

   // bank handed back once its last result has been transferred
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

// ===== hw/rtl/tie_group_label_stats.sv =====
// channel    direction  handshake            payload
// req_       in         push / full          score, is_positive, item_index
// rsp_       out        empty / pop          out_index, pos_count, neg_count,
//                                            left_border, right_border,
//                                            overflow, last_result
// csr_       in         csr_valid/csr_ready  item_count
//
// items are taken one per cycle while the other member bank is idle
// a closed group drains from its bank one result per cycle while pop is held; the next group
// takes its first member and then push stalls until that drain completes
// a stalled pop therefore also stalls push once a new group has opened
// a closed group passes through the group queue, then each result through the output register
// reset is synchronous; the member store needs no clearing pass
module tie_group_label_stats (
   input  logic                         clock,
   input  logic                         reset,
   // item channel
   input  logic                         push,
   output logic                         full,
   input  logic [tgls_pkg::SCORE_W-1:0] req_score,
   input  logic                         req_is_positive,
   input  logic [tgls_pkg::INDEX_W-1:0] req_item_index,
   // result channel
   output logic                         empty,
   input  logic                         pop,
   output logic [tgls_pkg::INDEX_W-1:0] rsp_out_index,
   output logic [tgls_pkg::COUNT_W-1:0] rsp_pos_count,
   output logic [tgls_pkg::COUNT_W-1:0] rsp_neg_count,
   output logic [tgls_pkg::RANK_W-1:0]  rsp_left_border,
   output logic [tgls_pkg::RANK_W-1:0]  rsp_right_border,
   output logic                         rsp_overflow,
   output logic                         rsp_last_result,
   // register write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tgls_pkg::COUNT_W-1:0] csr_item_count
);

   // member store write from the front
   logic                         mem_wr_en;
   logic [tgls_pkg::RAM_AW-1:0]  mem_wr_addr;
   logic [tgls_pkg::INDEX_W-1:0] mem_wr_data;
   logic [tgls_pkg::RAM_AW-1:0]  mem_rd_addr;

   // closed groups, at most two per transfer (score change plus end of set)
   logic                  push_a;
   logic                  push_b;
   tgls_pkg::desc_type    desc_a;
   tgls_pkg::desc_type    desc_b;
   logic                  head_valid;
   logic                  head_pop;
   tgls_pkg::desc_type    head;
   tgls_pkg::release_type rel;

   // front: tracks the open group, stores member indices, closes groups
   tgls_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_score      (req_score),
      .req_is_positive(req_is_positive),
      .req_item_index (req_item_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_item_count (csr_item_count),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .push_a         (push_a),
      .desc_a         (desc_a),
      .push_b         (push_b),
      .desc_b         (desc_b),
      .rel            (rel)
   );

   // two banks of member indices, bank bit on top of the address
   tgls_ram #(
      .WIDTH(tgls_pkg::INDEX_W),
      .DEPTH(tgls_pkg::RAM_DEPTH)
   ) u_members (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(rsp_out_index)
   );

   // queue of closed groups between front and back
   tgls_desc_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .desc_a    (desc_a),
      .push_b    (push_b),
      .desc_b    (desc_b),
      .head_valid(head_valid),
      .head      (head),
      .pop       (head_pop)
   );

   // back: walks each closed group's members into the output register
   tgls_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop),
      .rel             (rel),
      .mem_rd_addr     (mem_rd_addr),
      .empty           (empty),
      .pop             (pop),
      .rsp_pos_count   (rsp_pos_count),
      .rsp_neg_count   (rsp_neg_count),
      .rsp_left_border (rsp_left_border),
      .rsp_right_border(rsp_right_border),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// ===== hw/rtl/tgls_ram.sv =====
module tgls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tgls_front.sv =====
module tgls_front (
   input  logic                           clock,
   input  logic                           reset,
   // item channel
   input  logic                           push,
   output logic                           full,
   input  logic [tgls_pkg::SCORE_W-1:0]   req_score,
   input  logic                           req_is_positive,
   input  logic [tgls_pkg::INDEX_W-1:0]   req_item_index,
   // register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tgls_pkg::COUNT_W-1:0]   csr_item_count,
   // member store write
   output logic                           mem_wr_en,
   output logic [tgls_pkg::RAM_AW-1:0]    mem_wr_addr,
   output logic [tgls_pkg::INDEX_W-1:0]   mem_wr_data,
   // closed groups towards the queue
   output logic                           push_a,
   output tgls_pkg::desc_type             desc_a,
   output logic                           push_b,
   output tgls_pkg::desc_type             desc_b,
   input  tgls_pkg::release_type          rel
);

   logic [tgls_pkg::COUNT_W-1:0] item_count_ff, item_count_in;
   logic                         active_ff, active_in;
   logic                         cur_ff, cur_in;
   logic [1:0]                   busy_ff, busy_in;
   logic [tgls_pkg::COUNT_W-1:0] seen_ff, seen_in;
   logic [tgls_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [tgls_pkg::RANK_W-1:0]  first_ff, first_in;
   logic [tgls_pkg::COUNT_W-1:0] pos_ff, pos_in;
   logic [tgls_pkg::COUNT_W-1:0] neg_ff, neg_in;
   logic [tgls_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic                         ovf_ff, ovf_in;

   logic                         accept;
   logic                         close;
   logic                         new_grp;
   logic                         bank_new;
   logic                         is_last;
   logic                         room;
   logic [tgls_pkg::COUNT_W-1:0] nxt;
   logic [tgls_pkg::RANK_W-1:0]  p16;
   logic [tgls_pkg::RANK_W-1:0]  ic16;
   logic [tgls_pkg::RANK_W-1:0]  first0;
   logic [tgls_pkg::COUNT_W-1:0] pos0, neg0, pos1, neg1;
   logic [tgls_pkg::FILL_W-1:0]  fill0, fill1;
   logic                         ovf0, ovf1;
   logic [1:0]                   busy_set, busy_clr;

   // a score change needs the other bank, so an open group waits for it to be idle
   assign full      = active_ff ? busy_ff[~cur_ff] : busy_ff[cur_ff];
   assign accept    = push && !full;
   assign csr_ready = 1'b1;

   assign close    = active_ff && (req_score != score_ff);
   assign new_grp  = !active_ff || close;
   assign bank_new = close ? ~cur_ff : cur_ff;
   assign nxt      = seen_ff + tgls_pkg::COUNT_W'(1);
   assign is_last  = (nxt == item_count_ff);
   assign p16      = seen_ff[tgls_pkg::RANK_W-1:0];
   assign ic16     = item_count_ff[tgls_pkg::RANK_W-1:0];

   assign first0 = new_grp ? p16 : first_ff;
   assign pos0   = new_grp ? '0 : pos_ff;
   assign neg0   = new_grp ? '0 : neg_ff;
   assign fill0  = new_grp ? '0 : fill_ff;
   assign ovf0   = new_grp ? 1'b0 : ovf_ff;

   // counts saturate at the top of their range
   assign pos1 = (req_is_positive && pos0 != tgls_pkg::COUNT_MAX)
                 ? pos0 + tgls_pkg::COUNT_W'(1) : pos0;
   assign neg1 = (!req_is_positive && neg0 != tgls_pkg::COUNT_MAX)
                 ? neg0 + tgls_pkg::COUNT_W'(1) : neg0;

   assign room  = (fill0 < tgls_pkg::FILL_LIMIT);
   assign fill1 = room ? fill0 + tgls_pkg::FILL_W'(1) : fill0;
   assign ovf1  = ovf0 | !room;

   assign mem_wr_en   = accept && room;
   assign mem_wr_addr = {bank_new, fill0[tgls_pkg::GRP_AW-1:0]};
   assign mem_wr_data = req_item_index;

   // group closed by a score change, last member one position back
   assign push_a           = accept && close;
   assign desc_a.bank      = cur_ff;
   assign desc_a.fill      = fill_ff;
   assign desc_a.pos       = pos_ff;
   assign desc_a.neg       = neg_ff;
   assign desc_a.left      = ic16 - p16;
   assign desc_a.right     = ic16 - tgls_pkg::RANK_W'(1) - first_ff;
   assign desc_a.ovf       = ovf_ff;
   assign desc_a.ends_step = !is_last;

   // group closed by the end of the data set, this item included
   assign push_b           = accept && is_last;
   assign desc_b.bank      = bank_new;
   assign desc_b.fill      = fill1;
   assign desc_b.pos       = pos1;
   assign desc_b.neg       = neg1;
   assign desc_b.left      = ic16 - tgls_pkg::RANK_W'(1) - p16;
   assign desc_b.right     = ic16 - tgls_pkg::RANK_W'(1) - first0;
   assign desc_b.ovf       = ovf1;
   assign desc_b.ends_step = 1'b1;

   always_comb begin
      busy_set = '0;
      busy_clr = '0;
      if (push_a) begin
         busy_set[desc_a.bank] = 1'b1;
      end
      if (push_b) begin
         busy_set[desc_b.bank] = 1'b1;
      end
      if (rel.valid) begin
         busy_clr[rel.bank] = 1'b1;
      end
   end

   always_comb begin
      item_count_in = csr_valid ? csr_item_count : item_count_ff;
      busy_in       = (busy_ff | busy_set) & ~busy_clr;
      active_in     = active_ff;
      cur_in        = cur_ff;
      seen_in       = seen_ff;
      score_in      = score_ff;
      first_in      = first_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      fill_in       = fill_ff;
      ovf_in        = ovf_ff;
      if (accept) begin
         score_in = req_score;
         first_in = first0;
         pos_in   = pos1;
         neg_in   = neg1;
         fill_in  = fill1;
         ovf_in   = ovf1;
         if (is_last) begin
            active_in = 1'b0;
            cur_in    = ~bank_new;
            seen_in   = '0;
         end else begin
            active_in = 1'b1;
            cur_in    = bank_new;
            seen_in   = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= tgls_pkg::ITEM_COUNT_RST;
         active_ff     <= 1'b0;
         cur_ff        <= 1'b0;
         busy_ff       <= '0;
         seen_ff       <= '0;
         score_ff      <= '0;
         first_ff      <= '0;
         pos_ff        <= '0;
         neg_ff        <= '0;
         fill_ff       <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         item_count_ff <= item_count_in;
         active_ff     <= active_in;
         cur_ff        <= cur_in;
         busy_ff       <= busy_in;
         seen_ff       <= seen_in;
         score_ff      <= score_in;
         first_ff      <= first_in;
         pos_ff        <= pos_in;
         neg_ff        <= neg_in;
         fill_ff       <= fill_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

// ===== hw/rtl/tgls_desc_fifo.sv =====
module tgls_desc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_a,
   input  tgls_pkg::desc_type desc_a,
   input  logic               push_b,
   input  tgls_pkg::desc_type desc_b,
   output logic               head_valid,
   output tgls_pkg::desc_type head,
   input  logic               pop
);

   // two entries; at most one per bank, so a double push finds it empty
   tgls_pkg::desc_type entry_ff [2];
   tgls_pkg::desc_type entry_in [2];
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_slot;
   logic       do_pop;

   assign head_valid = (cnt_ff != 2'd0);
   assign head       = entry_ff[rd_ff];
   assign do_pop     = pop && head_valid;
   assign wr_slot    = rd_ff ^ cnt_ff[0];

   always_comb begin
      entry_in = entry_ff;
      if (push_a) begin
         entry_in[wr_slot] = desc_a;
      end
      if (push_b) begin
         entry_in[push_a ? ~wr_slot : wr_slot] = desc_b;
      end
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push_a) + 2'(push_b) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/tgls_back.sv =====
module tgls_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  tgls_pkg::desc_type           head,
   output logic                         head_pop,
   output tgls_pkg::release_type        rel,
   output logic [tgls_pkg::RAM_AW-1:0]  mem_rd_addr,
   // result channel, index comes straight from the member store
   output logic                         empty,
   input  logic                         pop,
   output logic [tgls_pkg::COUNT_W-1:0] rsp_pos_count,
   output logic [tgls_pkg::COUNT_W-1:0] rsp_neg_count,
   output logic [tgls_pkg::RANK_W-1:0]  rsp_left_border,
   output logic [tgls_pkg::RANK_W-1:0]  rsp_right_border,
   output logic                         rsp_overflow,
   output logic                         rsp_last_result
);

   logic [tgls_pkg::GRP_AW-1:0]  cnt_ff, cnt_in;
   logic                         out_valid_ff, out_valid_in;
   logic [tgls_pkg::RAM_AW-1:0]  out_addr_ff, out_addr_in;
   logic                         out_free_ff, out_free_in;
   logic                         out_last_ff, out_last_in;
   logic [tgls_pkg::COUNT_W-1:0] pos_ff, pos_in;
   logic [tgls_pkg::COUNT_W-1:0] neg_ff, neg_in;
   logic [tgls_pkg::RANK_W-1:0]  left_ff, left_in;
   logic [tgls_pkg::RANK_W-1:0]  right_ff, right_in;
   logic                         ovf_ff, ovf_in;

   logic pop_ok;
   logic load;
   logic last_mem;

   assign pop_ok   = pop && out_valid_ff;
   assign load     = head_valid && (!out_valid_ff || pop);
   assign last_mem = ((tgls_pkg::FILL_W'(cnt_ff) + tgls_pkg::FILL_W'(1)) == head.fill);
   assign head_pop = load && last_mem;

   // hold the address while stalled so the registered read keeps its data
   assign mem_rd_addr = load ? {head.bank, cnt_ff} : out_addr_ff;

   // bank stays busy until its last result leaves the output register
   assign rel.valid = pop_ok && out_free_ff;
   assign rel.bank  = out_addr_ff[tgls_pkg::RAM_AW-1];

   always_comb begin
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_free_in  = out_free_ff;
      out_last_in  = out_last_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      ovf_in       = ovf_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_addr_in  = {head.bank, cnt_ff};
         out_free_in  = last_mem;
         out_last_in  = head.ends_step && last_mem;
         pos_in       = head.pos;
         neg_in       = head.neg;
         left_in      = head.left;
         right_in     = head.right;
         ovf_in       = head.ovf;
         cnt_in       = last_mem ? '0 : cnt_ff + tgls_pkg::GRP_AW'(1);
      end else if (pop_ok) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff <= out_addr_in;
      out_free_ff <= out_free_in;
      out_last_ff <= out_last_in;
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      ovf_ff      <= ovf_in;
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty            = !out_valid_ff;
   assign rsp_pos_count    = pos_ff;
   assign rsp_neg_count    = neg_ff;
   assign rsp_left_border  = left_ff;
   assign rsp_right_border = right_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_last_result  = out_last_ff;

endmodule

// ===== hw/rtl/tgls_checker.sv =====
module tgls_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         empty,
   input logic                         pop,
   input logic [tgls_pkg::INDEX_W-1:0] rsp_out_index,
   input logic [tgls_pkg::COUNT_W-1:0] rsp_pos_count,
   input logic [tgls_pkg::COUNT_W-1:0] rsp_neg_count,
   input logic [tgls_pkg::RANK_W-1:0]  rsp_left_border,
   input logic [tgls_pkg::RANK_W-1:0]  rsp_right_border,
   input logic                         rsp_overflow,
   input logic                         rsp_last_result
);

   logic [tgls_pkg::COUNT_W:0] member_sum;

   assign member_sum = {1'b0, rsp_pos_count} + {1'b0, rsp_neg_count};

   // no result survives a reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result shown right after reset");

   // a reported group that did not overflow holds all its members
   a_fit_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_overflow) |->
         (member_sum >= (tgls_pkg::COUNT_W+1)'(1) &&
          member_sum <= (tgls_pkg::COUNT_W+1)'(tgls_pkg::MAX_GROUP)))
      else $error("group counts do not match a fitting group");

   // overflow only when more members were counted than can be stored
   a_ovf_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_overflow) |->
         member_sum > (tgls_pkg::COUNT_W+1)'(tgls_pkg::MAX_GROUP))
      else $error("overflow flagged on a small group");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=>
         (!empty && $stable(rsp_out_index) && $stable(rsp_pos_count) &&
          $stable(rsp_neg_count) && $stable(rsp_left_border) &&
          $stable(rsp_right_border) && $stable(rsp_overflow) &&
          $stable(rsp_last_result)))
      else $error("stalled result changed");

endmodule

bind tie_group_label_stats tgls_checker u_checker (.*);

// ===== verif/tie_group_label_stats_test.sv =====
module tie_group_label_stats_test;
   timeunit 1ns;
   timeprecision 1ps;

   // run length limits and pacing
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;

   // one input item as offered on the req_ ports
   typedef struct packed {
      logic [tgls_pkg::SCORE_W-1:0] score;
      logic                         positive;
      logic [tgls_pkg::INDEX_W-1:0] index;
   } item_rec_type;

   // one result as seen on the rsp_ ports
   typedef struct packed {
      logic [tgls_pkg::INDEX_W-1:0] index;
      logic [tgls_pkg::COUNT_W-1:0] pos;
      logic [tgls_pkg::COUNT_W-1:0] neg;
      logic [tgls_pkg::RANK_W-1:0]  left;
      logic [tgls_pkg::RANK_W-1:0]  right;
      logic                         ovf;
      logic                         last;
   } result_rec_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic [tgls_pkg::SCORE_W-1:0] req_score = '0;
   logic                         req_is_positive = 1'b0;
   logic [tgls_pkg::INDEX_W-1:0] req_item_index = '0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic [tgls_pkg::INDEX_W-1:0] rsp_out_index;
   logic [tgls_pkg::COUNT_W-1:0] rsp_pos_count;
   logic [tgls_pkg::COUNT_W-1:0] rsp_neg_count;
   logic [tgls_pkg::RANK_W-1:0]  rsp_left_border;
   logic [tgls_pkg::RANK_W-1:0]  rsp_right_border;
   logic                         rsp_overflow;
   logic                         rsp_last_result;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [tgls_pkg::COUNT_W-1:0] csr_item_count = '0;

   tie_group_label_stats dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_score        (req_score),
      .req_is_positive  (req_is_positive),
      .req_item_index   (req_item_index),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_index    (rsp_out_index),
      .rsp_pos_count    (rsp_pos_count),
      .rsp_neg_count    (rsp_neg_count),
      .rsp_left_border  (rsp_left_border),
      .rsp_right_border (rsp_right_border),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_item_count   (csr_item_count)
   );

   always #4 clock = ~clock;

   // items waiting for the driver, size writes waiting for the csr channel,
   // and the results the tie groups are due to report, oldest first
   item_rec_type                 pending_items[$];
   logic [tgls_pkg::COUNT_W-1:0] pending_sizes[$];
   result_rec_type               expected_results[$];
   result_rec_type               step_results[$];

   // pacing knobs, changed by the sequence between phases
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int mismatches     = 0;
   int cycle_count    = 0;
   logic [tgls_pkg::SCORE_W-1:0] gen_score = '0;

   // tie group tracker: open run of equal scores and the data set position
   logic [tgls_pkg::COUNT_W-1:0] set_size = tgls_pkg::ITEM_COUNT_RST;
   logic [tgls_pkg::COUNT_W-1:0] set_pos = '0;
   logic [tgls_pkg::SCORE_W-1:0] run_score = '0;
   logic                         run_open = 1'b0;
   logic [tgls_pkg::RANK_W-1:0]  run_first = '0;
   logic [tgls_pkg::COUNT_W-1:0] run_pos = '0;
   logic [tgls_pkg::COUNT_W-1:0] run_neg = '0;
   logic [tgls_pkg::INDEX_W-1:0] run_members[tgls_pkg::MAX_GROUP];
   int                           run_fill = 0;
   logic                         run_overflow = 1'b0;

   // close the open run: one result per stored member, in arrival order
   function automatic void close_run(input logic [tgls_pkg::COUNT_W-1:0] last_pos);
      logic [tgls_pkg::COUNT_W-1:0] span;
      result_rec_type r;
      span = set_size - 17'd1 - last_pos;
      r.pos   = run_pos;
      r.neg   = run_neg;
      r.left  = span[tgls_pkg::RANK_W-1:0];
      r.right = set_size[tgls_pkg::RANK_W-1:0] - 16'd1 - run_first;
      r.ovf   = run_overflow;
      r.last  = 1'b0;
      for (int i = 0; i < run_fill; i++) begin
         r.index = run_members[i];
         step_results.push_back(r);
      end
      run_open = 1'b0;
   endfunction

   // work out every result that one accepted item causes
   function automatic void tally_item(input item_rec_type it);
      logic [tgls_pkg::COUNT_W-1:0] p;
      logic [tgls_pkg::COUNT_W-1:0] nxt;
      result_rec_type r;
      step_results.delete();
      p = set_pos;
      nxt = p + 17'd1;
      // a score change closes the run that was open
      if (run_open && it.score != run_score) close_run(p - 17'd1);
      if (!run_open) begin
         run_score    = it.score;
         run_first    = p[tgls_pkg::RANK_W-1:0];
         run_pos      = '0;
         run_neg      = '0;
         run_fill     = 0;
         run_overflow = 1'b0;
         run_open     = 1'b1;
      end
      // label counts saturate at the top of their range
      if (it.positive) begin
         if (run_pos != tgls_pkg::COUNT_MAX) run_pos = run_pos + 17'd1;
      end else begin
         if (run_neg != tgls_pkg::COUNT_MAX) run_neg = run_neg + 17'd1;
      end
      // members past the store depth are counted but not reported
      if (run_fill < tgls_pkg::MAX_GROUP) begin
         run_members[run_fill] = it.index;
         run_fill++;
      end else begin
         run_overflow = 1'b1;
      end
      // last item of the data set flushes its own run too
      if (nxt == set_size) begin
         close_run(p);
         set_pos = '0;
      end else begin
         set_pos = nxt;
      end
      if (step_results.size() > 0) begin
         r = step_results.pop_back();
         r.last = 1'b1;
         step_results.push_back(r);
      end
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // driver: item transfers on push/full, register writes on csr_valid/csr_ready
   always @(posedge clock) begin : drive
      item_rec_type cur;
      item_rec_type head;
      if (reset) begin
         push <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         // a transfer of the offered item happens at this edge
         if (push && !full) begin
            cur.score    = req_score;
            cur.positive = req_is_positive;
            cur.index    = req_item_index;
            tally_item(cur);
         end
         // a new item may go out once the previous one is gone
         if (!push || !full) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               head = pending_items.pop_front();
               push            <= 1'b1;
               req_score       <= head.score;
               req_is_positive <= head.positive;
               req_item_index  <= head.index;
            end else begin
               push <= 1'b0;
            end
         end
         // size register writes, only issued while the block is idle
         if (csr_valid && csr_ready) begin
            set_size = csr_item_count;
            csr_valid <= 1'b0;
         end else if (!csr_valid && pending_sizes.size() > 0) begin
            csr_valid      <= 1'b1;
            csr_item_count <= pending_sizes.pop_front();
         end
      end
   end

   // long receiver hold-off, counted here so the sequence need not wait on it
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (holds_served != holds_asked) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_asked;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: every result transfer is checked against the oldest expectation
   always @(posedge clock) begin : watch
      result_rec_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected, out_index %0h", rsp_out_index);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("out_index", 32'(want.index), 32'(rsp_out_index));
               check_field("pos_count", 32'(want.pos), 32'(rsp_pos_count));
               check_field("neg_count", 32'(want.neg), 32'(rsp_neg_count));
               check_field("left_border", 32'(want.left), 32'(rsp_left_border));
               check_field("right_border", 32'(want.right), 32'(rsp_right_border));
               check_field("overflow", 32'(want.ovf), 32'(rsp_overflow));
               check_field("last_result", 32'(want.last), 32'(rsp_last_result));
            end
         end
         pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // runaway guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic queue_item(input logic [tgls_pkg::SCORE_W-1:0] s, input logic lbl,
                             input logic [tgls_pkg::INDEX_W-1:0] idx);
      item_rec_type it;
      it.score    = s;
      it.positive = lbl;
      it.index    = idx;
      pending_items.push_back(it);
   endtask

   // one tie run of random labels and indexes, mostly ascending scores
   task automatic add_run(input int len);
      if ($urandom_range(9) == 0) gen_score = $urandom;
      else gen_score = gen_score + 32'd1 + 32'($urandom_range(40));
      repeat (len) queue_item(gen_score, 1'($urandom_range(1)), 16'($urandom));
   endtask

   // mostly short runs, some medium, now and then one near or past the store depth
   task automatic add_groups(input int count);
      int remaining;
      int len;
      int pick;
      remaining = count;
      while (remaining > 0) begin
         pick = $urandom_range(99);
         if (pick < 55) len = $urandom_range(3, 1);
         else if (pick < 85) len = $urandom_range(10, 4);
         else len = $urandom_range(38, 31);
         if (len > remaining) len = remaining;
         add_run(len);
         remaining -= len;
      end
   endtask

   // items needed to finish the current data set and then more whole sets
   function automatic int items_to_close(input int n, input int sets);
      return n - int'(set_pos) + (sets - 1) * n;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() != 0 || push || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // size writes only once the block has gone quiet
   task automatic write_size(input logic [tgls_pkg::COUNT_W-1:0] n);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      pending_sizes.push_back(n);
      @(negedge clock);
      while (pending_sizes.size() != 0 || csr_valid) @(negedge clock);
   endtask

   task automatic set_pacing(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset size, score and index extremes, ties, out-of-order noise
      queue_item(32'h0000_0000, 1'b0, 16'h0000);
      queue_item(32'h0000_0000, 1'b1, 16'hFFFF);
      queue_item(32'h0000_0001, 1'b1, 16'h0001);
      queue_item(32'h0000_0005, 1'b0, 16'h1234);
      queue_item(32'h0000_0005, 1'b0, 16'h8000);
      queue_item(32'h0000_0005, 1'b1, 16'h7FFF);
      queue_item(32'h7FFF_FFFF, 1'b0, 16'h5555);
      queue_item(32'h8000_0000, 1'b1, 16'hAAAA);
      queue_item(32'h8000_0000, 1'b1, 16'h00FF);
      queue_item(32'hFFFF_FFFE, 1'b0, 16'hFF00);
      queue_item(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      queue_item(32'hFFFF_FFFF, 1'b0, 16'h0000);
      queue_item(32'hFFFF_FFFF, 1'b1, 16'h0F0F);
      queue_item(32'h0000_0010, 1'b0, 16'h0010);
      queue_item(32'h0000_0011, 1'b1, 16'h0011);
      queue_item(32'h0000_0020, 1'b0, 16'h0020);
      queue_item(32'h0000_0020, 1'b0, 16'h0021);
      queue_item(32'h0000_0030, 1'b1, 16'h0030);
      queue_item(32'h0000_0040, 1'b1, 16'h0040);
      queue_item(32'h0000_0040, 1'b0, 16'h0041);

      // size written mid-set, then the set ends on a score change,
      // so the closed run and the new one-member run flush together
      write_size(17'd24);
      queue_item(32'h0000_0040, 1'b1, 16'h0042);
      queue_item(32'h0000_0040, 1'b0, 16'h0043);
      queue_item(32'h0000_0041, 1'b1, 16'h0044);
      queue_item(32'h0000_0042, 1'b0, 16'h0045);

      // size one: every item is a set of its own
      write_size(17'd1);
      add_groups(8);

      // sender idles most cycles
      write_size(17'd9);
      set_pacing(83, 0);
      add_groups(items_to_close(9, 2));

      // receiver stalls, plus a long hold-off while the sender keeps offering
      write_size(17'd40);
      set_pacing(0, 83);
      holds_asked++;
      add_run(35);
      add_groups(items_to_close(40, 1) - 35);

      // large sizes: borders near the top of the rank range, partial sets
      write_size(17'd65535);
      set_pacing(10, 10);
      add_groups(6);
      write_size(17'd65536);
      set_pacing(0, 0);
      add_groups(4);

      // size zero: no item is ever last, so only a score change closes a run
      write_size(17'd0);
      repeat (3) queue_item(32'h0000_1000, 1'b1, 16'($urandom));
      queue_item(32'h0000_1000, 1'b0, 16'hBEEF);
      queue_item(32'h0000_1000, 1'b0, 16'h0BAD);
      queue_item(32'h0000_1001, 1'b1, 16'h1001);
      gen_score = 32'h0000_1001;

      // sender pauses until every result is in, then resumes
      write_size(17'd20);
      set_pacing(10, 10);
      add_groups(items_to_close(20, 1));
      wait_drained();
      set_pacing(0, 0);
      add_groups(20);

      write_size(17'd5);
      set_pacing(0, 83);
      add_groups(items_to_close(5, 2));

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tgls_pkg.sv
hw/rtl/tgls_ram.sv
hw/rtl/tgls_front.sv
hw/rtl/tgls_desc_fifo.sv
hw/rtl/tgls_back.sv
hw/rtl/tie_group_label_stats.sv
hw/rtl/tgls_checker.sv
verif/tie_group_label_stats_test.sv
